// ----- rtl/core/lru_device_name_cache_assert.svh -----
// Assertion macros for the device name cache
`ifndef LRU_DEVICE_NAME_CACHE_ASSERT_SVH
`define LRU_DEVICE_NAME_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

`define LRUDN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrudn assertion failed");

`define LRUDN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrudn assertion failed");

`else

`define LRUDN_ASSERT_IMP(lbl, ante, cons)

`define LRUDN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/lrudn_pkg.sv -----
// Shared types, constants and helpers for the device name cache
package lrudn_pkg;

    localparam int ENTRIES    = 5;
    localparam int NAME_WORDS = 4;
    localparam int KEY_W      = 56;
    localparam int STAMP_W    = 32;
    localparam int WORD_W     = 64;
    localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDX_W     = $clog2(NAME_WORDS);
    localparam int SCAN_LEN   = (ENTRIES > NAME_WORDS) ? ENTRIES : NAME_WORDS;
    localparam int CNT_W      = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic        command;
        logic [47:0] dev_address;
        logic [7:0]  dev_addr_kind;
        logic [63:0] name_word0;
        logic [63:0] name_word1;
        logic [63:0] name_word2;
        logic [63:0] name_word3;
        logic [31:0] now_ms;
    } lrudn_req_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  entry_slot;
        logic [63:0] out_name0;
        logic [63:0] out_name1;
        logic [63:0] out_name2;
        logic [63:0] out_name3;
    } lrudn_rsp_t;

    typedef struct packed {
        logic match;
        logic older;
    } lrudn_probe_t;

    typedef logic [WORD_W-1:0] name_t [NAME_WORDS];

    function automatic logic [KEY_W-1:0] req_key(input lrudn_req_t req);
        return {req.dev_addr_kind, req.dev_address};
    endfunction

    function automatic logic [WORD_W-1:0] req_word(input lrudn_req_t req,
                                                   input logic [WIDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            2'd0:    w = req.name_word0;
            2'd1:    w = req.name_word1;
            2'd2:    w = req.name_word2;
            default: w = req.name_word3;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/lrudn_probe.sv -----
// Shared compare unit: key equality and timestamp ordering for one entry
module lrudn_probe
    import lrudn_pkg::*;
(
    input  logic [KEY_W-1:0]   entry_key,
    input  logic [KEY_W-1:0]   probe_key,
    input  logic [STAMP_W-1:0] entry_stamp,
    input  logic [STAMP_W-1:0] best_stamp,
    output lrudn_probe_t       verdict
);

    assign verdict.match = (entry_key == probe_key);
    assign verdict.older = (entry_stamp < best_stamp);

endmodule

// ----- rtl/core/lrudn_clean.sv -----
// Name word cleaner: zero every byte from the first zero byte onwards, and the final byte of the last word
module lrudn_clean
    import lrudn_pkg::*;
(
    input  logic [WORD_W-1:0] word_in,
    input  logic              ended_in,
    input  logic              last_word,
    output logic [WORD_W-1:0] word_out,
    output logic              ended_out
);

    logic [8:0] ended_chain;

    always_comb
    begin
        ended_chain[0] = ended_in;
        for (int b = 0; b < 8; b++)
        begin
            ended_chain[b+1] = ended_chain[b] || (word_in[8*b +: 8] == 8'h00)
                               || (last_word && (b == 7));
            word_out[8*b +: 8] = ended_chain[b+1] ? 8'h00 : word_in[8*b +: 8];
        end
    end

    assign ended_out = ended_chain[8];

endmodule

// ----- rtl/core/lru_device_name_cache.sv -----
// Top level: device name cache with entry scan sequencer and stores
//
//   channel   direction  handshake            payload
//   request   in         start && !busy       lrudn_req_t
//   result    out        done (one cycle)     lrudn_rsp_t
//
// An accepted request enters the SCAN state, which compares one entry
// through the shared probe unit and cleans one name word per cycle; the
// FINISH state then updates the stores and registers the result.
// busy is low again in the cycle that carries done, so a new request may
// be accepted there. Reset clears all stores to zero at once; no sweep.
// The receiver cannot stall: done stands for exactly one cycle.
module lru_device_name_cache
    import lrudn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  lrudn_req_t request,
    output logic       done,
    output lrudn_rsp_t result
);

`include "lru_device_name_cache_assert.svh"

    typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    lrudn_req_t          req_reg,    req_next;
    logic                found_reg,  found_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic [SLOT_W-1:0]   victim_reg, victim_next;
    logic [STAMP_W-1:0]  oldest_reg, oldest_next;
    logic                ended_reg,  ended_next;
    name_t               clean_reg,  clean_next;
    logic                done_reg,   done_next;
    lrudn_rsp_t          result_reg, result_next;

    logic [KEY_W-1:0]    key_store_reg   [ENTRIES];
    logic [KEY_W-1:0]    key_store_next  [ENTRIES];
    logic [STAMP_W-1:0]  stamp_store_reg [ENTRIES];
    logic [STAMP_W-1:0]  stamp_store_next[ENTRIES];
    name_t               name_store_reg  [ENTRIES];
    name_t               name_store_next [ENTRIES];

    logic [SLOT_W-1:0]   eidx;
    logic [WIDX_W-1:0]   widx;
    logic                entry_live;
    logic                word_live;
    logic [SLOT_W-1:0]   target;
    lrudn_probe_t        verdict;
    logic [WORD_W-1:0]   word_clean;
    logic                word_ended;

    assign eidx       = SLOT_W'(cnt_reg);
    assign widx       = WIDX_W'(cnt_reg);
    assign entry_live = ({1'b0, cnt_reg} < (CNT_W+1)'(ENTRIES));
    assign word_live  = ({1'b0, cnt_reg} < (CNT_W+1)'(NAME_WORDS));
    assign target     = found_reg ? slot_reg : victim_reg;

    lrudn_probe u_probe (
        .entry_key   (key_store_reg[entry_live ? eidx : '0]),
        .probe_key   (req_key(req_reg)),
        .entry_stamp (stamp_store_reg[entry_live ? eidx : '0]),
        .best_stamp  (oldest_reg),
        .verdict     (verdict)
    );

    lrudn_clean u_clean (
        .word_in   (req_word(req_reg, widx)),
        .ended_in  (ended_reg),
        .last_word (widx == WIDX_W'(NAME_WORDS - 1)),
        .word_out  (word_clean),
        .ended_out (word_ended)
    );

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        req_next         = req_reg;
        found_next       = found_reg;
        slot_next        = slot_reg;
        victim_next      = victim_reg;
        oldest_next      = oldest_reg;
        ended_next       = ended_reg;
        clean_next       = clean_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        key_store_next   = key_store_reg;
        stamp_store_next = stamp_store_reg;
        name_store_next  = name_store_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    ended_next = 1'b0;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (entry_live)
                begin
                    if (verdict.match && !found_reg)
                    begin
                        found_next = 1'b1;
                        slot_next  = eidx;
                    end
                    if ((cnt_reg == '0) || verdict.older)
                    begin
                        oldest_next = stamp_store_reg[eidx];
                        victim_next = eidx;
                    end
                end
                if (word_live)
                begin
                    clean_next[widx] = word_clean;
                    ended_next       = word_ended;
                end
                if (cnt_reg == CNT_W'(SCAN_LEN - 1))
                    state_next = FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            FINISH:
            begin
                result_next     = '0;
                result_next.hit = found_reg;
                if (req_reg.command == CMD_STORE)
                begin
                    if (!found_reg)
                        key_store_next[target] = req_key(req_reg);
                    name_store_next[target]  = clean_reg;
                    stamp_store_next[target] = req_reg.now_ms;
                    result_next.entry_slot   = 3'(target);
                end
                else if (found_reg)
                begin
                    result_next.entry_slot = 3'(slot_reg);
                    result_next.out_name0  = name_store_reg[slot_reg][0];
                    result_next.out_name1  = name_store_reg[slot_reg][1];
                    result_next.out_name2  = name_store_reg[slot_reg][2];
                    result_next.out_name3  = name_store_reg[slot_reg][3];
                end
                done_next  = 1'b1;
                state_next = IDLE;
            end
            default:
                state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            cnt_reg    <= '0;
            req_reg    <= '0;
            found_reg  <= 1'b0;
            slot_reg   <= '0;
            victim_reg <= '0;
            oldest_reg <= '0;
            ended_reg  <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            for (int i = 0; i < NAME_WORDS; i++)
                clean_reg[i] <= '0;
            for (int e = 0; e < ENTRIES; e++)
            begin
                key_store_reg[e]   <= '0;
                stamp_store_reg[e] <= '0;
                for (int i = 0; i < NAME_WORDS; i++)
                    name_store_reg[e][i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            req_reg         <= req_next;
            found_reg       <= found_next;
            slot_reg        <= slot_next;
            victim_reg      <= victim_next;
            oldest_reg      <= oldest_next;
            ended_reg       <= ended_next;
            clean_reg       <= clean_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
            key_store_reg   <= key_store_next;
            stamp_store_reg <= stamp_store_next;
            name_store_reg  <= name_store_next;
        end
    end

    assign busy   = (state_reg != IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `LRUDN_ASSERT_NEXT(a_finish_done, state_reg == FINISH, done)
    `LRUDN_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
    `LRUDN_ASSERT_IMP(a_slot_range, done, result.entry_slot < 3'(ENTRIES))
    `LRUDN_ASSERT_IMP(a_store_no_name, done && (req_reg.command == CMD_STORE), (result.out_name0 == '0) && (result.out_name3 == '0))

endmodule
